>>> hw/rtl/fcsem_pkg.sv
// Package for the FIFO counting semaphore: widths, request/result item types,
// status and kind codes, controller state and controller/datapath interface.
// No dependencies.
package fcsem_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QIdxW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned TidW       = 8;
  localparam int unsigned CountW     = 16;
  localparam int unsigned UnitsW     = 16;

  // Request kinds
  localparam logic [1:0] KIND_WAIT   = 2'd0;
  localparam logic [1:0] KIND_SIGNAL = 2'd1;
  localparam logic [1:0] KIND_CLOSE  = 2'd2;

  // Result kinds
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_WAKE   = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_CLOSED  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TidW-1:0]   thread_id;
    logic [UnitsW-1:0] units;
  } req_t;

  typedef struct packed {
    logic            result_kind;
    logic [1:0]      status;
    logic [TidW-1:0] woken_thread;
    logic            woken_by_close;
    logic            last;
  } rsp_t;

  // One waiter entry of the queue
  typedef struct packed {
    logic [TidW-1:0]   tid;
    logic [UnitsW-1:0] need;
  } waiter_t;

  typedef enum logic [0:0] {
    CTRL_IDLE = 1'b0,
    CTRL_WALK = 1'b1
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;      // apply the accepted request
    logic step;      // retire the pending result, maybe wake the head
    logic load_cfg;  // reload count, empty queue, reopen
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic more;      // another wake follows the pending result
    logic out_free;  // output register can take an item this cycle
  } dp_stat_t;

endpackage

>>> hw/rtl/fcsem_ctrl.sv
// Controller of the FIFO counting semaphore: two-state sequencer that accepts a
// request, then walks the waiter queue one item per cycle while the output is free. Uses fcsem_pkg.
module fcsem_ctrl import fcsem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cfg_ready_o   = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.load_cfg = 1'b0;
    case (state_q)
      CTRL_IDLE: begin
        in_stall_o     = 1'b0;
        // Hold off a register write while a request is offered
        cfg_ready_o    = !in_valid_i;
        cmd_o.load_cfg = cfg_valid_i && !in_valid_i;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = CTRL_WALK;
        end
      end
      CTRL_WALK: begin
        // Retire one item per cycle while the output can take it
        if (stat_i.out_free) begin
          cmd_o.step = 1'b1;
          if (!stat_i.more) begin
            state_d = CTRL_IDLE;
          end
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/fcsem_dp.sv
// Datapath of the FIFO counting semaphore: count, closed flag, waiter queue
// memory with registered head read, pending result and output register.
// Uses fcsem_pkg.
module fcsem_dp import fcsem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  req_t              req_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output rsp_t              out_item_o,
  output dp_stat_t          stat_o
);

  localparam logic [QIdxW-1:0] LastIdx = QIdxW'(QueueDepth - 1);

  logic [CountW-1:0] count_q, count_d;
  logic              closed_q, closed_d;
  logic [QIdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [QCntW-1:0]  occ_q, occ_d;
  logic              walk_q, walk_d;
  logic              by_close_q, by_close_d;
  rsp_t              pend_q, pend_d;
  rsp_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;
  waiter_t           mem [QueueDepth];
  waiter_t           rd_q;
  logic              we;
  waiter_t           wdata;
  logic [CountW:0]   sum;
  logic [CountW-1:0] sat_sum;
  logic              more;

  assign out_valid_o     = out_vld_q;
  assign out_item_o      = out_q;
  assign stat_o.out_free = !out_vld_q || !out_stall_i;
  assign stat_o.more     = more;

  // Saturating add for a signal
  assign sum     = {1'b0, count_q} + (CountW + 1)'(req_i.units);
  assign sat_sum = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];

  // Head wakes when the walk is on and it fits, or on close
  assign more = walk_q && (occ_q != '0) &&
                (by_close_q || ((CountW + 1)'(rd_q.need) <= (CountW + 1)'(count_q)));

  assign wdata.tid  = req_i.thread_id;
  assign wdata.need = req_i.units;

  always_comb begin
    count_d    = count_q;
    closed_d   = closed_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    walk_d     = walk_q;
    by_close_d = by_close_q;
    pend_d     = pend_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    we         = 1'b0;

    // Drop the output item once taken
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    // Reload from the configuration register
    if (cmd_i.load_cfg) begin
      count_d  = cfg_data_i;
      closed_d = 1'b0;
      head_d   = '0;
      tail_d   = '0;
      occ_d    = '0;
    end

    // Apply a request and prepare its status item
    if (cmd_i.exec) begin
      pend_d             = '0;
      pend_d.result_kind = RK_STATUS;
      pend_d.status      = ST_OK;
      walk_d             = 1'b0;
      by_close_d         = 1'b0;
      case (req_i.kind)
        KIND_WAIT: begin
          if (closed_q) begin
            pend_d.status = ST_CLOSED;
          end else if (req_i.units == '0) begin
            pend_d.status = ST_OK;
          end else if ((CountW + 1)'(count_q) >= (CountW + 1)'(req_i.units)) begin
            count_d = count_q - CountW'(req_i.units);
          end else if (occ_q == QCntW'(QueueDepth)) begin
            pend_d.status = ST_FULL;
          end else begin
            we            = 1'b1;
            tail_d        = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
            occ_d         = occ_q + 1'b1;
            pend_d.status = ST_BLOCKED;
          end
        end
        KIND_SIGNAL: begin
          if (closed_q) begin
            pend_d.status = ST_CLOSED;
          end else begin
            count_d = sat_sum;
            walk_d  = 1'b1;
          end
        end
        KIND_CLOSE: begin
          closed_d   = 1'b1;
          walk_d     = 1'b1;
          by_close_d = 1'b1;
        end
        default: begin
          pend_d.status = ST_OK;
        end
      endcase
    end

    // Retire the pending item; if the head wakes, it becomes the next pending
    if (cmd_i.step) begin
      out_d      = pend_q;
      out_d.last = !more;
      out_vld_d  = 1'b1;
      if (more) begin
        pend_d.result_kind    = RK_WAKE;
        pend_d.status         = ST_OK;
        pend_d.woken_thread   = rd_q.tid;
        pend_d.woken_by_close = by_close_q;
        pend_d.last           = 1'b0;
        if (!by_close_q) begin
          count_d = count_q - CountW'(rd_q.need);
        end
        head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
        occ_d  = occ_q - 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      closed_q   <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      walk_q     <= 1'b0;
      by_close_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      closed_q   <= closed_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      walk_q     <= walk_d;
      by_close_q <= by_close_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Waiter queue: write at tail, registered read of the next head entry
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tail_q] <= wdata;
    end
    if (we && (tail_q == head_d)) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem[head_d];
    end
  end

endmodule

>>> hw/rtl/fifo_counting_semaphore.sv
// Counting semaphore with a FIFO of waiters. Every request, a refused one or an
// unknown kind too, yields one status item; a signal or close also yields one wake
// item per woken thread, the queue walk retiring one item a cycle through the output
// register unless it stalls. Reset gives count 0, open, empty queue;
// queue storage needs no clearing. Uses fcsem_pkg, fcsem_ctrl and fcsem_dp.
module fifo_counting_semaphore import fcsem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  fcsem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Count, queue and result registers
  fcsem_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_item_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .stat_o      (stat)
  );

endmodule

>>> hw/rtl/fcsem_chk.sv
// Port checker for the FIFO counting semaphore, bound to the top level.
// Uses fcsem_pkg.
module fcsem_chk import fcsem_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input req_t              in_item_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rsp_t              out_item_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [CountW-1:0] cfg_data_i
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // An accepted item blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Configuration is only taken while the input side is open
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("configuration ready while busy");

  // Wake items carry status ok
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == RK_WAKE) |-> out_item_o.status == ST_OK)
    else $error("wake item with nonzero status");

  // Status items carry no thread and no close flag
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == RK_STATUS) |->
      (out_item_o.woken_thread == '0) && !out_item_o.woken_by_close)
    else $error("status item with wake fields set");

endmodule

bind fifo_counting_semaphore fcsem_chk u_fcsem_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);
